[rtl/core/rank_four_tensor_engine_top_assert.svh]
// Assertion macros for the rank-four tensor engine checker.
// Used by rfte_checker only; no other dependencies.
`ifndef RANK_FOUR_TENSOR_ENGINE_TOP_ASSERT_SVH
`define RANK_FOUR_TENSOR_ENGINE_TOP_ASSERT_SVH

// Clocked assertion, disabled while reset is high.
`define RFTE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define RFTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/rfte_pkg.sv]
// Shared types, constants and helpers for the rank-four tensor engine.
// No dependencies.
package rfte_pkg;

   localparam int DIM_DEFAULT = 3;
   localparam int FRAC_BITS   = 16;

   localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7fff_ffff;
   localparam logic signed [63:0] S32_MIN = 64'shffff_ffff_8000_0000;

   typedef enum logic [2:0] {
      OP_CLEAR     = 3'd0,
      OP_WRITE     = 3'd1,
      OP_READ      = 3'd2,
      OP_ADD       = 3'd3,
      OP_MAT_WRITE = 3'd4,
      OP_SCALE     = 3'd5,
      OP_CONTRACT  = 3'd6,
      OP_ROTATE    = 3'd7
   } opcode_type;

   typedef enum logic {
      MAC_MUL = 1'b0,
      MAC_ACC = 1'b1
   } mac_mode_type;

   typedef struct packed {
      logic         start;
      logic         acc_clr;
      mac_mode_type mode;
   } mac_ctrl_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > S32_MAX) begin
         return S32_MAX[31:0];
      end else if (v < S32_MIN) begin
         return S32_MIN[31:0];
      end
      return v[31:0];
   endfunction

endpackage

[rtl/core/rfte_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rfte_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 81
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/rfte_mac.sv]
// Shared Q16.16 multiplier with floor, saturation and a 64-bit accumulator.
// Depends on rfte_pkg.
module rfte_mac import rfte_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  mac_ctrl_type       ctrl,
   input  logic signed [31:0] a,
   input  logic signed [31:0] b,
   output logic               done,
   output logic signed [31:0] result
);

   logic signed [63:0] prod_ff;
   mac_mode_type       mode_ff;
   logic               stage_ff;
   logic               done_ff;
   logic signed [63:0] acc_ff;
   logic signed [31:0] res_ff;
   logic signed [63:0] floored;
   logic signed [63:0] acc_in;

   // arithmetic shift floors toward minus infinity
   assign floored = prod_ff >>> FRAC_BITS;
   assign acc_in  = acc_ff + floored;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
         done_ff  <= 1'b0;
         acc_ff   <= '0;
      end else begin
         stage_ff <= ctrl.start;
         done_ff  <= stage_ff;
         if (ctrl.acc_clr) begin
            acc_ff <= '0;
         end else if (stage_ff && mode_ff == MAC_ACC) begin
            acc_ff <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         prod_ff <= a * b;
         mode_ff <= ctrl.mode;
      end
      if (stage_ff) begin
         res_ff <= (mode_ff == MAC_ACC) ? sat32(acc_in) : sat32(floored);
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

[rtl/core/rank_four_tensor_engine_top.sv]
// Rank-four tensor engine: DIM^4 tensor and DIM x DIM matrix of Q16.16 values.
// Depends on rfte_pkg, rfte_ram and rfte_mac.
//
// Requests enter on req_valid/req_stall with an opcode, an element index and
// an operand; one request is taken at a time and req_stall stays high until
// its work is done. Results leave on rsp_valid/rsp_stall from an output
// register: a read gives one result, a contraction DIM*DIM results with
// rsp_last_result on the final one; other opcodes give none.
// All multiplies run through one 32x32 multiplier (issue plus two stages in
// the unit); the add opcode uses its own saturating adder. Rotate writes
// its sums to a scratch copy and then copies that back into the tensor.
// Reset (synchronous, active high) zeros the tensor at once through per-entry
// valid bits, zeros the matrix and empties the output register. While the
// receiver stalls, a waiting result holds and the engine pauses before
// producing the next one.
module rank_four_tensor_engine_top import rfte_pkg::*; #(
   parameter int DIM = DIM_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_opcode,
   input  logic [6:0]         req_elem_index,
   input  logic signed [31:0] req_operand_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_result_value,
   output logic [6:0]         rsp_result_index,
   output logic               rsp_last_result
);

   localparam int D2 = DIM * DIM;
   localparam int D4 = D2 * D2;
   localparam int CW = $clog2(DIM);
   localparam int MW = $clog2(D2);
   localparam int AW = $clog2(D4);
   localparam logic [CW-1:0] DMAX = CW'(DIM - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_ELEM_WAIT, S_FETCH, S_MUL, S_MUL_WAIT,
      S_EMIT, S_COPY_RD, S_COPY_WR
   } state_type;

   typedef enum logic [2:0] {
      PH_ROW, PH_COL, PH_DEPTH, PH_LAST, PH_TERM
   } phase_type;

   state_type          state_ff;
   phase_type          phase_ff;
   opcode_type         op_ff;
   logic [6:0]         idx_ff;
   logic signed [31:0] val_ff;
   logic [CW-1:0]      i_ff, j_ff, k_ff, l_ff, m_ff, n_ff, o_ff, p_ff;
   logic signed [31:0] r1_ff, r2_ff, r3_ff, r4_ff;
   logic signed [31:0] matrix_ff [D2];
   logic [D4-1:0]      valid_ff;
   logic               rd_valid_ff;
   logic signed [31:0] em_value_ff;
   logic [6:0]         em_index_ff;
   logic               em_last_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_value_ff;
   logic [6:0]         rsp_index_ff;
   logic               rsp_last_ff;

   logic               in_range, mat_range, out_free;
   logic [AW-1:0]      ijkl_addr, mnop_addr;
   logic [MW-1:0]      mat_addr;
   logic signed [31:0] mat_q, t_q, add_sat;
   logic [CW-1:0]      i_in, j_in, k_in, l_in, m_in, n_in, o_in, p_in;
   logic               cl, ck, cj, ci, cp, co, cn, cm;

   logic               t_we, t_re, s_we, s_re;
   logic [AW-1:0]      t_waddr, t_raddr, s_waddr, s_raddr;
   logic [31:0]        t_wdata, s_wdata, t_rdata, s_rdata;
   mac_ctrl_type       mac_ctrl;
   logic signed [31:0] mac_a, mac_b, mac_res;
   logic               mac_done;

   function automatic logic [AW-1:0] idx4(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                          input logic [CW-1:0] c, input logic [CW-1:0] d);
      return AW'(((int'(a) * DIM + int'(b)) * DIM + int'(c)) * DIM + int'(d));
   endfunction

   function automatic logic [MW-1:0] idx2(input logic [CW-1:0] a, input logic [CW-1:0] b);
      return MW'(int'(a) * DIM + int'(b));
   endfunction

   assign in_range  = int'(idx_ff) < D4;
   assign mat_range = int'(idx_ff) < D2;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign ijkl_addr = idx4(i_ff, j_ff, k_ff, l_ff);
   assign mnop_addr = idx4(m_ff, n_ff, o_ff, p_ff);
   assign t_q       = rd_valid_ff ? t_rdata : '0;
   assign add_sat   = sat32(64'(t_q) + 64'(val_ff));
   assign mat_q     = matrix_ff[mat_addr];

   // counters as base-DIM digits, last digit fastest
   always_comb begin
      cl   = l_ff == DMAX;
      ck   = cl && k_ff == DMAX;
      cj   = ck && j_ff == DMAX;
      ci   = cj && i_ff == DMAX;
      l_in = cl ? '0 : l_ff + 1'b1;
      k_in = !cl ? k_ff : (ck ? '0 : k_ff + 1'b1);
      j_in = !ck ? j_ff : (cj ? '0 : j_ff + 1'b1);
      i_in = !cj ? i_ff : (ci ? '0 : i_ff + 1'b1);
      cp   = p_ff == DMAX;
      co   = cp && o_ff == DMAX;
      cn   = co && n_ff == DMAX;
      cm   = cn && m_ff == DMAX;
      p_in = cp ? '0 : p_ff + 1'b1;
      o_in = !cp ? o_ff : (co ? '0 : o_ff + 1'b1);
      n_in = !co ? n_ff : (cn ? '0 : n_ff + 1'b1);
      m_in = !cn ? m_ff : (cm ? '0 : m_ff + 1'b1);
   end

   always_comb begin
      case (phase_ff)
         PH_ROW:   mat_addr = idx2(i_ff, m_ff);
         PH_COL:   mat_addr = idx2(j_ff, n_ff);
         PH_DEPTH: mat_addr = idx2(k_ff, o_ff);
         PH_LAST:  mat_addr = idx2(l_ff, p_ff);
         default:  mat_addr = idx2(k_ff, l_ff);
      endcase
      if (op_ff == OP_CONTRACT) begin
         mat_addr = idx2(k_ff, l_ff);
      end
   end

   // memory ports and shared unit control
   always_comb begin
      t_we     = 1'b0;
      t_waddr  = ijkl_addr;
      t_wdata  = mac_res;
      t_re     = 1'b0;
      t_raddr  = ijkl_addr;
      s_we     = 1'b0;
      s_waddr  = ijkl_addr;
      s_wdata  = mac_res;
      s_re     = 1'b0;
      s_raddr  = ijkl_addr;
      mac_ctrl = '{start: 1'b0, acc_clr: 1'b0, mode: MAC_MUL};
      mac_a    = t_q;
      mac_b    = mat_q;
      case (state_ff)
         S_DISPATCH: begin
            case (op_ff)
               OP_WRITE: begin
                  t_we    = in_range;
                  t_waddr = AW'(idx_ff);
                  t_wdata = val_ff;
               end
               OP_READ, OP_ADD: begin
                  t_re    = in_range;
                  t_raddr = AW'(idx_ff);
               end
               OP_SCALE, OP_CONTRACT, OP_ROTATE: mac_ctrl.acc_clr = 1'b1;
               default: ;
            endcase
         end
         S_ELEM_WAIT: begin
            t_we    = op_ff == OP_ADD && in_range;
            t_waddr = AW'(idx_ff);
            t_wdata = add_sat;
         end
         S_FETCH: begin
            t_re    = 1'b1;
            t_raddr = (op_ff == OP_ROTATE) ? mnop_addr : ijkl_addr;
         end
         S_MUL: begin
            mac_ctrl.start = !(op_ff == OP_ROTATE && phase_ff == PH_ROW);
            mac_ctrl.mode  = (op_ff == OP_CONTRACT ||
                              (op_ff == OP_ROTATE && phase_ff == PH_TERM)) ? MAC_ACC : MAC_MUL;
            if (op_ff == OP_SCALE) begin
               mac_b = val_ff;
            end else if (op_ff == OP_ROTATE) begin
               case (phase_ff)
                  PH_COL:   mac_a = r1_ff;
                  PH_DEPTH: mac_a = r2_ff;
                  PH_LAST:  mac_a = r3_ff;
                  PH_TERM: begin
                     mac_a = r4_ff;
                     mac_b = t_q;
                  end
                  default: ;
               endcase
            end
         end
         S_MUL_WAIT: begin
            if (mac_done) begin
               if (op_ff == OP_SCALE) begin
                  t_we = 1'b1;
               end else if (op_ff == OP_ROTATE && phase_ff == PH_TERM && cm) begin
                  s_we             = 1'b1;
                  mac_ctrl.acc_clr = 1'b1;
               end
            end
         end
         S_EMIT: mac_ctrl.acc_clr = out_free && op_ff == OP_CONTRACT && !em_last_ff;
         S_COPY_RD: s_re = 1'b1;
         S_COPY_WR: begin
            t_we    = 1'b1;
            t_wdata = s_rdata;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_ROW;
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int e = 0; e < D2; e++) begin
            matrix_ff[e] <= '0;
         end
      end else begin
         if (t_re) begin
            rd_valid_ff <= valid_ff[t_raddr];
         end
         if (state_ff == S_DISPATCH && op_ff == OP_CLEAR) begin
            valid_ff <= '0;
         end else if (t_we) begin
            valid_ff[t_waddr] <= 1'b1;
         end
         // drop a taken result unless the emit state loads the next one
         if (rsp_valid_ff && !rsp_stall && state_ff != S_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff    <= opcode_type'(req_opcode);
                  idx_ff   <= req_elem_index;
                  val_ff   <= req_operand_value;
                  state_ff <= S_DISPATCH;
               end
            end
            S_DISPATCH: begin
               i_ff <= '0; j_ff <= '0; k_ff <= '0; l_ff <= '0;
               m_ff <= '0; n_ff <= '0; o_ff <= '0; p_ff <= '0;
               phase_ff <= PH_ROW;
               case (op_ff)
                  OP_READ:  state_ff <= S_ELEM_WAIT;
                  OP_ADD:   state_ff <= in_range ? S_ELEM_WAIT : S_IDLE;
                  OP_MAT_WRITE: begin
                     if (mat_range) begin
                        matrix_ff[MW'(idx_ff)] <= val_ff;
                     end
                     state_ff <= S_IDLE;
                  end
                  OP_SCALE, OP_CONTRACT: state_ff <= S_FETCH;
                  OP_ROTATE: state_ff <= S_MUL;
                  default:   state_ff <= S_IDLE;
               endcase
            end
            S_ELEM_WAIT: begin
               if (op_ff == OP_READ) begin
                  em_value_ff <= in_range ? t_q : '0;
                  em_index_ff <= idx_ff;
                  em_last_ff  <= 1'b1;
                  state_ff    <= S_EMIT;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_FETCH: state_ff <= S_MUL;
            S_MUL: begin
               if (op_ff == OP_ROTATE && phase_ff == PH_ROW) begin
                  r1_ff    <= mat_q;
                  phase_ff <= PH_COL;
               end else begin
                  state_ff <= S_MUL_WAIT;
               end
            end
            S_MUL_WAIT: begin
               if (mac_done) begin
                  case (op_ff)
                     OP_SCALE: begin
                        {i_ff, j_ff, k_ff, l_ff} <= {i_in, j_in, k_in, l_in};
                        state_ff <= ci ? S_IDLE : S_FETCH;
                     end
                     OP_CONTRACT: begin
                        {i_ff, j_ff, k_ff, l_ff} <= {i_in, j_in, k_in, l_in};
                        if (ck) begin
                           em_value_ff <= mac_res;
                           em_index_ff <= 7'(int'(i_ff) * DIM + int'(j_ff));
                           em_last_ff  <= ci;
                           state_ff    <= S_EMIT;
                        end else begin
                           state_ff <= S_FETCH;
                        end
                     end
                     default: begin
                        case (phase_ff)
                           PH_COL: begin
                              r2_ff    <= mac_res;
                              phase_ff <= PH_DEPTH;
                              state_ff <= S_MUL;
                           end
                           PH_DEPTH: begin
                              r3_ff    <= mac_res;
                              phase_ff <= PH_LAST;
                              state_ff <= S_MUL;
                           end
                           PH_LAST: begin
                              r4_ff    <= mac_res;
                              phase_ff <= PH_TERM;
                              state_ff <= S_FETCH;
                           end
                           default: begin
                              {m_ff, n_ff, o_ff, p_ff} <= {m_in, n_in, o_in, p_in};
                              if (!cp) begin
                                 phase_ff <= PH_LAST;
                                 state_ff <= S_MUL;
                              end else if (!co) begin
                                 phase_ff <= PH_DEPTH;
                                 state_ff <= S_MUL;
                              end else if (!cm) begin
                                 phase_ff <= PH_ROW;
                                 state_ff <= S_MUL;
                              end else begin
                                 // element done: advance to the next output element
                                 {i_ff, j_ff, k_ff, l_ff} <= {i_in, j_in, k_in, l_in};
                                 phase_ff <= PH_ROW;
                                 state_ff <= ci ? S_COPY_RD : S_MUL;
                              end
                           end
                        endcase
                     end
                  endcase
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_value_ff <= em_value_ff;
                  rsp_index_ff <= em_index_ff;
                  rsp_last_ff  <= em_last_ff;
                  state_ff     <= (op_ff == OP_CONTRACT && !em_last_ff) ? S_FETCH : S_IDLE;
               end
            end
            S_COPY_RD: state_ff <= S_COPY_WR;
            S_COPY_WR: begin
               {i_ff, j_ff, k_ff, l_ff} <= {i_in, j_in, k_in, l_in};
               state_ff <= ci ? S_IDLE : S_COPY_RD;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   rfte_ram #(.WIDTH(32), .DEPTH(D4)) u_tensor (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (t_waddr),
      .wr_data (t_wdata),
      .rd_en   (t_re),
      .rd_addr (t_raddr),
      .rd_data (t_rdata)
   );

   rfte_ram #(.WIDTH(32), .DEPTH(D4)) u_scratch (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_en   (s_re),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   rfte_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .a      (mac_a),
      .b      (mac_b),
      .done   (mac_done),
      .result (mac_res)
   );

   assign req_stall        = state_ff != S_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_last_result  = rsp_last_ff;

endmodule

[rtl/core/rfte_checker.sv]
// Port-level checker for the rank-four tensor engine, bound to the top level.
// Depends on rfte_pkg and rank_four_tensor_engine_top_assert.svh.
`include "rank_four_tensor_engine_top_assert.svh"

module rfte_checker import rfte_pkg::*; #(
   parameter int DIM = DIM_DEFAULT
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_result_value,
   input logic [6:0]         rsp_result_index,
   input logic               rsp_last_result
);

   localparam int D2 = DIM * DIM;

   // a taken request always blocks the next one
   `RFTE_ASSERT(a_req_blocks, clock, reset, (req_valid && !req_stall) |=> req_stall, "request not held off")
   `RFTE_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_result_value) && $stable(rsp_result_index) && $stable(rsp_last_result)), "stalled result changed")
   // only a contraction gives unmarked results, and never its final index
   `RFTE_ASSERT(a_rsp_index, clock, reset, (rsp_valid && !rsp_last_result) |-> (int'(rsp_result_index) < D2 - 1), "unmarked result index out of range")
   `RFTE_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> (!rsp_valid && !req_stall), "engine busy after reset")

endmodule

bind rank_four_tensor_engine_top rfte_checker #(.DIM(DIM)) u_rfte_checker (.*);

[tb/rank_four_tensor_engine_top_test.sv]
// Self-checking testbench for rank_four_tensor_engine_top (DIM = 3).
// Depends on rfte_pkg and the engine RTL; a built-in predictor tracks the
// tensor and matrix and checks every read and contraction result in order.
module rank_four_tensor_engine_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import rfte_pkg::*;

   localparam int N = 3;
   localparam int N2 = N * N;
   localparam int N4 = N2 * N2;

   typedef struct {
      opcode_type         op;
      logic [6:0]         idx;
      logic signed [31:0] val;
      bit                 known;
      logic signed [31:0] known_val;
   } stim_row_t;

   typedef struct {
      logic signed [31:0] value;
      logic [6:0]         index;
      logic               last;
   } tensor_result_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [2:0]         req_opcode = 3'd0;
   logic [6:0]         req_elem_index = 7'd0;
   logic signed [31:0] req_operand_value = 32'sd0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_result_value;
   logic [6:0]         rsp_result_index;
   logic               rsp_last_result;

   logic signed [31:0] tensor_model [N4];
   logic signed [31:0] matrix_model [N2];
   tensor_result_t     pending_results [$];

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  mismatches = 0;
   int  results_checked = 0;
   int  reads_sent = 0;
   int  contracts_sent = 0;
   int  rotates_sent = 0;
   int  scales_sent = 0;

   rank_four_tensor_engine_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_opcode(req_opcode), .req_elem_index(req_elem_index),
      .req_operand_value(req_operand_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_value(rsp_result_value), .rsp_result_index(rsp_result_index),
      .rsp_last_result(rsp_last_result)
   );

   always #4 clock = ~clock;

   initial begin
      #40_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sh0000_0000_7fff_ffff) begin
         return 32'h7fff_ffff;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   // exact 64-bit product, floored by 16 fraction bits
   function automatic logic signed [63:0] fx_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      logic signed [63:0] wa;
      logic signed [63:0] wb;
      wa = a;
      wb = b;
      return (wa * wb) >>> 16;
   endfunction

   task automatic rotate_model();
      logic signed [31:0] scratch [N4];
      logic signed [63:0] acc;
      logic signed [31:0] r2, r3, r4;
      for (int i = 0; i < N; i++)
      for (int j = 0; j < N; j++)
      for (int k = 0; k < N; k++)
      for (int l = 0; l < N; l++) begin
         acc = 0;
         for (int m = 0; m < N; m++)
         for (int n = 0; n < N; n++) begin
            r2 = clamp32(fx_mul(matrix_model[i*N+m], matrix_model[j*N+n]));
            for (int o = 0; o < N; o++) begin
               r3 = clamp32(fx_mul(r2, matrix_model[k*N+o]));
               for (int p = 0; p < N; p++) begin
                  r4 = clamp32(fx_mul(r3, matrix_model[l*N+p]));
                  acc += fx_mul(r4, tensor_model[((m*N+n)*N+o)*N+p]);
               end
            end
         end
         scratch[((i*N+j)*N+k)*N+l] = clamp32(acc);
      end
      tensor_model = scratch;
   endtask

   // update the model for one accepted request and queue its results
   task automatic apply_request(input stim_row_t r);
      tensor_result_t res;
      logic signed [63:0] acc;
      logic signed [63:0] wide;
      case (r.op)
         OP_CLEAR: foreach (tensor_model[e]) tensor_model[e] = 0;
         OP_WRITE: if (r.idx < N4) tensor_model[r.idx] = r.val;
         OP_READ: begin
            res.value = (r.idx < N4) ? tensor_model[r.idx] : 32'sd0;
            if (r.known) res.value = r.known_val;
            res.index = r.idx;
            res.last = 1'b1;
            pending_results.push_back(res);
         end
         OP_ADD: if (r.idx < N4) begin
            wide = tensor_model[r.idx];
            wide += r.val;
            tensor_model[r.idx] = clamp32(wide);
         end
         OP_MAT_WRITE: if (r.idx < N2) matrix_model[r.idx] = r.val;
         OP_SCALE: foreach (tensor_model[e]) tensor_model[e] = clamp32(fx_mul(tensor_model[e], r.val));
         OP_CONTRACT: begin
            for (int i = 0; i < N; i++)
            for (int j = 0; j < N; j++) begin
               acc = 0;
               for (int k = 0; k < N; k++)
                  for (int l = 0; l < N; l++)
                     acc += fx_mul(tensor_model[((i*N+j)*N+k)*N+l], matrix_model[k*N+l]);
               res.value = clamp32(acc);
               res.index = 7'(i*N+j);
               res.last = (i*N+j == N2-1);
               pending_results.push_back(res);
            end
         end
         default: rotate_model();
      endcase
   endtask

   task automatic send_request(input stim_row_t r);
      if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= r.op;
      req_elem_index <= r.idx;
      req_operand_value <= r.val;
      do @(posedge clock); while (req_stall);
      apply_request(r);
      case (r.op)
         OP_READ:     reads_sent++;
         OP_CONTRACT: contracts_sent++;
         OP_ROTATE:   rotates_sent++;
         OP_SCALE:    scales_sent++;
         default: ;
      endcase
   endtask

   task automatic drain_results();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // result side: check accepted results, then choose the next stall
   always @(posedge clock) begin
      tensor_result_t want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: value %h index %0d last %b",
                           rsp_result_value, rsp_result_index, rsp_last_result);
            end else begin
               want = pending_results.pop_front();
               if (rsp_result_value !== want.value || rsp_result_index !== want.index ||
                   rsp_last_result !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                              want.value, want.index, want.last,
                              rsp_result_value, rsp_result_index, rsp_last_result);
               end
            end
         end
      end
      rsp_stall <= (recv_idle_pct > 0) && ($urandom_range(0, 99) < recv_idle_pct);
   end

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2, 3: return $urandom();
         default: return $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
      endcase
   endfunction

   function automatic stim_row_t random_row(input int rotate_budget);
      stim_row_t r;
      int pick;
      pick = $urandom_range(0, 99);
      r.known = 1'b0;
      r.known_val = 0;
      r.val = pick_value();
      r.idx = ($urandom_range(0, 15) == 0) ? 7'($urandom_range(0, 127))
                                            : 7'($urandom_range(0, N4-1));
      if (pick < 24) r.op = OP_WRITE;
      else if (pick < 46) r.op = OP_READ;
      else if (pick < 56) r.op = OP_ADD;
      else if (pick < 70) begin
         r.op = OP_MAT_WRITE;
         if (r.idx < N4) r.idx = 7'($urandom_range(0, N2-1));
         // keep the matrix near unit size so rotations stay meaningful
         r.val = $signed(32'($urandom_range(0, 32'h0003_0000))) - 32'sh0001_8000;
      end else if (pick < 78) begin
         r.op = OP_SCALE;
         if ($urandom_range(0, 3) != 0)
            r.val = $signed(32'($urandom_range(32'h0000_c000, 32'h0001_4000)));
      end else if (pick < 94) r.op = OP_CONTRACT;
      else if (pick < 97) r.op = OP_CLEAR;
      else if (rotate_budget > 0) r.op = OP_ROTATE;
      else r.op = OP_READ;
      return r;
   endfunction

   stim_row_t directed_plan [] = '{
      '{OP_READ,      7'd0,   32'sd0,          1'b1, 32'sd0},
      '{OP_READ,      7'd80,  32'sd0,          1'b1, 32'sd0},
      '{OP_READ,      7'd127, 32'sd0,          1'b1, 32'sd0},
      '{OP_WRITE,     7'd0,   32'sh7fff_ffff,  1'b0, 32'sd0},
      '{OP_READ,      7'd0,   32'sd0,          1'b1, 32'sh7fff_ffff},
      '{OP_ADD,       7'd0,   32'sd1,          1'b0, 32'sd0},
      '{OP_READ,      7'd0,   32'sd0,          1'b1, 32'sh7fff_ffff},
      '{OP_WRITE,     7'd80,  -32'sh8000_0000, 1'b0, 32'sd0},
      '{OP_ADD,       7'd80,  -32'sd1,         1'b0, 32'sd0},
      '{OP_READ,      7'd80,  32'sd0,          1'b1, -32'sh8000_0000},
      '{OP_WRITE,     7'd127, 32'sh1234_5678,  1'b0, 32'sd0},
      '{OP_ADD,       7'd81,  32'sh0001_0000,  1'b0, 32'sd0},
      '{OP_READ,      7'd81,  32'sd0,          1'b1, 32'sd0},
      '{OP_CONTRACT,  7'd0,   32'sd0,          1'b0, 32'sd0},
      '{OP_MAT_WRITE, 7'd0,   32'sh0001_0000,  1'b0, 32'sd0},
      '{OP_MAT_WRITE, 7'd4,   32'sh0001_0000,  1'b0, 32'sd0},
      '{OP_MAT_WRITE, 7'd8,   -32'sh0001_0000, 1'b0, 32'sd0},
      '{OP_MAT_WRITE, 7'd127, 32'sh7fff_ffff,  1'b0, 32'sd0},
      '{OP_WRITE,     7'd40,  32'sh0002_8000,  1'b0, 32'sd0},
      '{OP_CONTRACT,  7'd0,   32'sd0,          1'b0, 32'sd0},
      '{OP_SCALE,     7'd0,   -32'sh0000_8000, 1'b0, 32'sd0},
      '{OP_ROTATE,    7'd0,   32'sd0,          1'b0, 32'sd0},
      '{OP_READ,      7'd0,   32'sd0,          1'b0, 32'sd0},
      '{OP_CLEAR,     7'd0,   32'sd0,          1'b0, 32'sd0},
      '{OP_READ,      7'd40,  32'sd0,          1'b1, 32'sd0}
   };

   initial begin
      int rotate_budget;
      foreach (tensor_model[e]) tensor_model[e] = 0;
      foreach (matrix_model[e]) matrix_model[e] = 0;
      rotate_budget = 4;
      send_idle_pct = 6;
      recv_idle_pct = 56;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[n]) send_request(directed_plan[n]);

      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 56;
            recv_idle_pct = 6;
         end else if (phase == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int n = 0; n < 62; n++) begin
            stim_row_t r;
            r = random_row(rotate_budget);
            if (r.op == OP_ROTATE) rotate_budget--;
            send_request(r);
         end
         // hold new requests until every outstanding result is back
         if (phase == 0) begin
            req_valid <= 1'b0;
            drain_results();
         end
      end
      req_valid <= 1'b0;

      drain_results();
      repeat (100) @(posedge clock);
      $display("Covered %0d reads, %0d contractions, %0d scales, %0d rotations;",
               reads_sent, contracts_sent, scales_sent, rotates_sent);
      $display("%0d results checked, %0d mismatches.", results_checked, mismatches);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/rfte_pkg.sv
rtl/core/rfte_ram.sv
rtl/core/rfte_mac.sv
rtl/core/rank_four_tensor_engine_top.sv
rtl/core/rfte_checker.sv
tb/rank_four_tensor_engine_top_test.sv
